// ----- src/alarm_event_ring_log_assert.svh -----
// ----------------------------------------------------------------------------
// alarm_event_ring_log_assert.svh
// Assertion macros for the alarm event ring log; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ALARM_EVENT_RING_LOG_ASSERT_SVH
`define ALARM_EVENT_RING_LOG_ASSERT_SVH

`ifndef SYNTHESIS

`define AERL_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define AERL_ASSERT(lbl, prop, msg) \
    `AERL_ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)

`else

`define AERL_ASSERT_CLK(lbl, clk, rst_n, prop, msg)

`define AERL_ASSERT(lbl, prop, msg)

`endif

`endif

// ----- src/aerl_pkg.sv -----
// ----------------------------------------------------------------------------
// aerl_pkg
// Shared sizes, entry and result layouts and sequencer states of the
// alarm event ring log.
// ----------------------------------------------------------------------------
`default_nettype none

package aerl_pkg;

    localparam int ENTRIES   = 32;
    localparam int AW        = $clog2(ENTRIES);
    localparam int CW        = $clog2(ENTRIES + 1);
    localparam int CODE_W    = 8;
    localparam int TS_W      = 32;
    localparam int STORED_W  = 6;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [TS_W-1:0]   start_ts;
        logic [TS_W-1:0]   end_ts;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic                entry_valid;
        logic [CODE_W-1:0]   entry_code;
        logic [TS_W-1:0]     entry_start;
        logic [TS_W-1:0]     entry_end;
        logic                has_duration;
        logic [TS_W-1:0]     duration;
        logic [STORED_W-1:0] stored_count;
        logic                final_of_run;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CLOSE,
        S_WRITE,
        S_RESP,
        S_DRD,
        S_DLD
    } t_state;

endpackage

`default_nettype wire

// ----- src/alarm_event_ring_log.sv -----
// ----------------------------------------------------------------------------
// alarm_event_ring_log
// Circular log of alarm episodes held in one entry RAM.
//
// Input channel: i_valid / o_stall with i_mode, i_alarm_code, i_timestamp.
// Output channel: o_valid / i_stall with one port per result field.
// A mode 0 transaction updates the log and gives one result carrying the
// entry count. A mode 1 transaction dumps the entries oldest first, one
// result each, with final_of_run on the last; an empty log gives a single
// result with entry_valid low.
// An update that changes the code may take a read-modify-write of the
// newest entry and a write of the new entry; an unchanged code or an
// empty dump answers without touching the RAM. A dump reads each entry
// and then loads it into the output register, as set by the single read
// port of the entry RAM and its registered read. One transaction is
// worked on at a time; o_stall stays high until its last result sits in
// the output register. Reset clears head, count and last code; RAM
// contents are not cleared and never read before being written. While
// i_stall is high a valid output result holds and the next one waits.
// ----------------------------------------------------------------------------
`default_nettype none

`include "alarm_event_ring_log_assert.svh"

module alarm_event_ring_log
    import aerl_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic              i_mode,
    input  wire logic [CODE_W-1:0] i_alarm_code,
    input  wire logic [TS_W-1:0]   i_timestamp,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic                   o_entry_valid,
    output logic [CODE_W-1:0]      o_entry_code,
    output logic [TS_W-1:0]        o_entry_start,
    output logic [TS_W-1:0]        o_entry_end,
    output logic                   o_has_duration,
    output logic [TS_W-1:0]        o_duration,
    output logic [STORED_W-1:0]    o_stored_count,
    output logic                   o_final_of_run
);

    t_state            r_state, n_state;
    logic [AW-1:0]     r_head, n_head;
    logic [CW-1:0]     r_count, n_count;
    logic [CODE_W-1:0] r_prev, n_prev;
    logic [CODE_W-1:0] r_code, n_code;
    logic [TS_W-1:0]   r_ts, n_ts;
    logic [CW-1:0]     r_idx, n_idx;
    logic [AW-1:0]     r_addr, n_addr;
    t_result           r_out, n_out;
    logic              r_out_valid, n_out_valid;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    t_entry            ram_wdata;
    logic [AW-1:0]     ram_raddr;
    t_entry            ram_rdata;

    logic              out_free;
    logic              in_acc;
    logic              dump_last;
    logic [AW-1:0]     newest;
    logic [AW-1:0]     head_next;
    logic [AW-1:0]     addr_next;

    aerl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_stall   = (r_state != S_IDLE);
    assign in_acc    = i_valid && (r_state == S_IDLE);
    assign out_free  = !r_out_valid || !i_stall;
    assign dump_last = ((r_idx + CW'(1)) == r_count);
    assign newest    = (r_head == '0) ? AW'(ENTRIES - 1) : (r_head - AW'(1));
    assign head_next = (r_head == AW'(ENTRIES - 1)) ? '0 : (r_head + AW'(1));
    assign addr_next = (r_addr == AW'(ENTRIES - 1)) ? '0 : (r_addr + AW'(1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_mode) begin
                        n_state = (r_count == '0) ? S_RESP : S_DRD;
                    end else if (i_alarm_code == r_prev) begin
                        n_state = S_RESP;
                    end else if ((r_prev != '0) && (r_count != '0)) begin
                        n_state = S_RD;
                    end else if (i_alarm_code != '0) begin
                        n_state = S_WRITE;
                    end else begin
                        n_state = S_RESP;
                    end
                end
            end
            S_RD:    n_state = S_CLOSE;
            S_CLOSE: n_state = (r_code != '0) ? S_WRITE : S_RESP;
            S_WRITE: n_state = S_RESP;
            S_RESP:  n_state = out_free ? S_IDLE : S_RESP;
            S_DRD:   n_state = out_free ? S_DLD : S_DRD;
            S_DLD:   n_state = dump_last ? S_IDLE : S_DRD;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and RAM control
    always_comb begin
        n_head      = r_head;
        n_count     = r_count;
        n_prev      = r_prev;
        n_code      = r_code;
        n_ts        = r_ts;
        n_idx       = r_idx;
        n_addr      = r_addr;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_stall;
        ram_we      = 1'b0;
        ram_waddr   = r_head;
        ram_wdata   = '0;
        ram_raddr   = r_addr;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_ts   = i_timestamp;
                    n_code = i_alarm_code;
                    n_idx  = '0;
                    n_addr = (r_count < CW'(ENTRIES)) ? '0 : r_head;
                    if (!i_mode && (i_alarm_code != r_prev)) begin
                        n_prev = i_alarm_code;
                    end
                end
            end
            S_RD: begin
                ram_raddr = newest;
            end
            S_CLOSE: begin
                // close the open episode only
                if (ram_rdata.end_ts == '0) begin
                    ram_we           = 1'b1;
                    ram_waddr        = newest;
                    ram_wdata        = ram_rdata;
                    ram_wdata.end_ts = r_ts;
                end
            end
            S_WRITE: begin
                ram_we             = 1'b1;
                ram_waddr          = r_head;
                ram_wdata.code     = r_code;
                ram_wdata.start_ts = r_ts;
                ram_wdata.end_ts   = '0;
                n_head             = head_next;
                if (r_count < CW'(ENTRIES)) begin
                    n_count = r_count + CW'(1);
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_out              = '0;
                    n_out.stored_count = STORED_W'(r_count);
                    n_out.final_of_run = 1'b1;
                    n_out_valid        = 1'b1;
                end
            end
            S_DRD: begin
                ram_raddr = r_addr;
            end
            S_DLD: begin
                n_out.entry_valid  = 1'b1;
                n_out.entry_code   = ram_rdata.code;
                n_out.entry_start  = ram_rdata.start_ts;
                n_out.entry_end    = ram_rdata.end_ts;
                n_out.has_duration = ram_rdata.end_ts > ram_rdata.start_ts;
                n_out.duration     = (ram_rdata.end_ts > ram_rdata.start_ts)
                                   ? (ram_rdata.end_ts - ram_rdata.start_ts) : '0;
                n_out.stored_count = STORED_W'(r_count);
                n_out.final_of_run = dump_last;
                n_out_valid        = 1'b1;
                n_idx              = r_idx + CW'(1);
                n_addr             = addr_next;
            end
            default: begin
                n_out_valid = r_out_valid && i_stall;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_prev      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_prev      <= n_prev;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code <= n_code;
        r_ts   <= n_ts;
        r_idx  <= n_idx;
        r_addr <= n_addr;
        r_out  <= n_out;
    end

    assign o_valid        = r_out_valid;
    assign o_entry_valid  = r_out.entry_valid;
    assign o_entry_code   = r_out.entry_code;
    assign o_entry_start  = r_out.entry_start;
    assign o_entry_end    = r_out.entry_end;
    assign o_has_duration = r_out.has_duration;
    assign o_duration     = r_out.duration;
    assign o_stored_count = r_out.stored_count;
    assign o_final_of_run = r_out.final_of_run;

    `AERL_ASSERT(a_count_bound, (r_count <= CW'(ENTRIES)), "entry count above capacity")
    `AERL_ASSERT(a_count_step, ((r_count != $past(r_count)) |-> (r_count == ($past(r_count) + CW'(1)))), "entry count moved by other than one")
    `AERL_ASSERT(a_head_write, ((r_head != $past(r_head)) |-> ($past(r_state) == S_WRITE)), "head moved outside an entry write")
    `AERL_ASSERT(a_dump_slot_free, ((r_state == S_DLD) |-> !r_out_valid), "dump data arrived while output register busy")

endmodule

`default_nettype wire

// ----- src/aerl_ram.sv -----
// ----------------------------------------------------------------------------
// aerl_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module aerl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire
